[hdl/h2dfr_pkg.sv]
// Shared constants for the HTTP/2 frame deframer: phase, result kind and
// error codes, frame type and flag values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package h2dfr_pkg;

  // Header is 9 bytes; index of its last byte
  localparam int unsigned HDR_BYTES = 9;
  localparam logic [3:0] HDR_LAST_IDX = 4'(HDR_BYTES - 1);

  // Parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_PADLEN = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_PAD    = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_DEAD   = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_TOO_LONG    = 3'd0;
  localparam logic [2:0] ERR_STREAM_ZERO = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN     = 3'd2;
  localparam logic [2:0] ERR_BAD_FLAGS   = 3'd3;
  localparam logic [2:0] ERR_PAD_MISSING = 3'd4;
  localparam logic [2:0] ERR_PAD_LONG    = 3'd5;
  localparam logic [2:0] ERR_PAD_NONZERO = 3'd6;
  localparam logic [2:0] ERR_NONE        = 3'd0;

  // Frame types and flags
  localparam logic [7:0] TYPE_DATA       = 8'h00;
  localparam logic [7:0] TYPE_SETTINGS   = 8'h04;
  localparam logic [7:0] TYPE_LAST_KNOWN = 8'h09;
  localparam logic [7:0] FLAG_END_STREAM = 8'h01;
  localparam logic [7:0] FLAG_PADDED     = 8'h08;
  localparam logic [7:0] STREAM_TOP_MASK = 8'h7f;

  // Reset value of the maximum frame size register
  localparam logic [23:0] MAX_FRAME_RESET = 24'(1 << 14);

endpackage : h2dfr_pkg

`default_nettype wire

[hdl/http2_frame_deframer.sv]
// HTTP/2 frame deframer: byte-serial frame header parser and DATA payload
// extractor. Depends on h2dfr_pkg.
//
// Usage:
//   Input channel in_valid / in_stall / in_byte carries the connection byte
//   stream, one byte per transfer. Result channel out_valid / out_stall
//   carries one result per producing byte: header ready, data byte, frame
//   end or error, with the current header fields alongside.
//   cfg_valid / cfg_ready / cfg_max_frame_size writes the maximum payload
//   length; cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   A byte is parsed in the cycle of its transfer against the frame state;
//   its result, if any, appears in the output register on the next cycle.
//   One byte per cycle is sustained if out_stall is low. The state update
//   is one counter step and compare; only the output register limits it.
// Stall:
//   in_stall is raised only while a result waits and out_stall is high; a
//   result taken in the same cycle frees the register for the next byte.
// Reset:
//   rst_n (synchronous) clears the parser to header collection, empties the
//   output register and restores max frame size to 16384. After an error
//   is reported, every byte is taken and dropped until reset.
`timescale 1ns / 1ps
`default_nettype none

module http2_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_max_frame_size,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_frame_type,
  output logic [7:0]       out_frame_flags,
  output logic [23:0]      out_frame_length,
  output logic [30:0]      out_stream_id,
  output logic [2:0]       out_error_code,
  output logic             out_frame_end
);
  import h2dfr_pkg::*;

  // Parser state
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [23:0] len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [30:0] stream_r, stream_nxt;
  logic [23:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  pad_left_r, pad_left_nxt;
  logic [23:0] max_size_r;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r;
  logic [7:0]  dbyte_r;
  logic [7:0]  otype_r;
  logic [7:0]  oflags_r;
  logic [23:0] olen_r;
  logic [30:0] ostream_r;
  logic [2:0]  err_r;
  logic        fend_r;

  // Per-byte result
  logic        emit;
  logic [1:0]  kind_nxt;
  logic [7:0]  dbyte_nxt;
  logic [2:0]  err_nxt;
  logic        fend_nxt;

  logic        accept;
  logic        load_out;
  logic [23:0] bl_dec;
  logic [23:0] bl_after_pad;
  logic [7:0]  pad_dec;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign load_out  = accept && emit;

  assign bl_dec       = bytes_left_r - 24'd1;
  assign pad_dec      = pad_left_r - 8'd1;
  assign bl_after_pad = len_r - 24'd1 - {16'd0, in_byte};

  // Parse one byte against the frame state
  always_comb begin
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    len_nxt        = len_r;
    type_nxt       = type_r;
    flags_nxt      = flags_r;
    stream_nxt     = stream_r;
    bytes_left_nxt = bytes_left_r;
    pad_left_nxt   = pad_left_r;
    emit           = 1'b0;
    kind_nxt       = KIND_HEADER;
    dbyte_nxt      = 8'd0;
    err_nxt        = ERR_NONE;
    fend_nxt       = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        // gather the header field this byte belongs to
        case (hdr_idx_r)
          4'd0: len_nxt = {in_byte, 16'd0};
          4'd1: len_nxt = {len_r[23:16], in_byte, len_r[7:0]};
          4'd2: len_nxt = {len_r[23:8], in_byte};
          4'd3: type_nxt = in_byte;
          4'd4: flags_nxt = in_byte;
          4'd5: stream_nxt = {in_byte[6:0], 24'd0};
          4'd6: stream_nxt = {stream_r[30:24], in_byte, stream_r[15:0]};
          4'd7: stream_nxt = {stream_r[30:16], in_byte, stream_r[7:0]};
          default: stream_nxt = {stream_r[30:8], in_byte};
        endcase

        if (hdr_idx_r >= HDR_LAST_IDX) begin
          // header complete: validate it
          hdr_idx_nxt = 4'd0;
          emit        = 1'b1;
          if (len_nxt > max_size_r) begin
            phase_nxt = PH_DEAD; kind_nxt = KIND_ERROR;
            err_nxt = ERR_TOO_LONG; fend_nxt = 1'b1;
          end else if (stream_nxt == 31'd0 && type_nxt != TYPE_SETTINGS) begin
            phase_nxt = PH_DEAD; kind_nxt = KIND_ERROR;
            err_nxt = ERR_STREAM_ZERO; fend_nxt = 1'b1;
          end else if (type_nxt > TYPE_LAST_KNOWN) begin
            phase_nxt = PH_DEAD; kind_nxt = KIND_ERROR;
            err_nxt = ERR_UNKNOWN; fend_nxt = 1'b1;
          end else begin
            pad_left_nxt = 8'd0;
            if (type_nxt == TYPE_DATA) begin
              if ((flags_nxt & ~(FLAG_END_STREAM | FLAG_PADDED)) != 8'd0) begin
                phase_nxt = PH_DEAD; kind_nxt = KIND_ERROR;
                err_nxt = ERR_BAD_FLAGS; fend_nxt = 1'b1;
              end else if ((flags_nxt & FLAG_PADDED) != 8'd0) begin
                if (len_nxt == 24'd0) begin
                  phase_nxt = PH_DEAD; kind_nxt = KIND_ERROR;
                  err_nxt = ERR_PAD_MISSING; fend_nxt = 1'b1;
                end else begin
                  phase_nxt = PH_PADLEN;
                end
              end else begin
                bytes_left_nxt = len_nxt;
                phase_nxt      = (len_nxt == 24'd0) ? PH_HEADER : PH_DATA;
                fend_nxt       = (len_nxt == 24'd0);
              end
            end else begin
              bytes_left_nxt = len_nxt;
              phase_nxt      = (len_nxt == 24'd0) ? PH_HEADER : PH_SKIP;
              fend_nxt       = (len_nxt == 24'd0);
            end
          end
        end else begin
          hdr_idx_nxt = hdr_idx_r + 4'd1;
        end
      end

      PH_PADLEN: begin
        // pad length must leave room inside the payload
        if ({16'd0, in_byte} >= len_r) begin
          phase_nxt = PH_DEAD; emit = 1'b1; kind_nxt = KIND_ERROR;
          err_nxt = ERR_PAD_LONG; fend_nxt = 1'b1;
        end else begin
          pad_left_nxt   = in_byte;
          bytes_left_nxt = bl_after_pad;
          if (bl_after_pad != 24'd0) begin
            phase_nxt = PH_DATA;
          end else if (in_byte != 8'd0) begin
            phase_nxt = PH_PAD;
          end else begin
            phase_nxt = PH_HEADER; emit = 1'b1;
            kind_nxt = KIND_END; fend_nxt = 1'b1;
          end
        end
      end

      PH_DATA: begin
        // pass the payload byte through
        bytes_left_nxt = bl_dec;
        emit           = 1'b1;
        kind_nxt       = KIND_DATA;
        dbyte_nxt      = in_byte;
        if (bl_dec == 24'd0) begin
          if (pad_left_r == 8'd0) begin
            phase_nxt = PH_HEADER;
            fend_nxt  = 1'b1;
          end else begin
            phase_nxt = PH_PAD;
          end
        end
      end

      PH_PAD: begin
        // padding must be zero
        if (in_byte != 8'd0) begin
          phase_nxt = PH_DEAD; emit = 1'b1; kind_nxt = KIND_ERROR;
          err_nxt = ERR_PAD_NONZERO; fend_nxt = 1'b1;
        end else begin
          pad_left_nxt = pad_dec;
          if (pad_dec == 8'd0) begin
            phase_nxt = PH_HEADER; emit = 1'b1;
            kind_nxt = KIND_END; fend_nxt = 1'b1;
          end
        end
      end

      PH_SKIP: begin
        // drop the payload of a non-DATA frame
        bytes_left_nxt = bl_dec;
        if (bl_dec == 24'd0) begin
          phase_nxt = PH_HEADER; emit = 1'b1;
          kind_nxt = KIND_END; fend_nxt = 1'b1;
        end
      end

      default: begin
        // dead after an error: drop everything
        phase_nxt = phase_r;
      end
    endcase
  end

  // Hold a result until it is taken; load a new one on a producing byte
  assign out_valid_nxt = load_out || (out_valid_r && out_stall);

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_idx_r    <= 4'd0;
      len_r        <= 24'd0;
      type_r       <= 8'd0;
      flags_r      <= 8'd0;
      stream_r     <= 31'd0;
      bytes_left_r <= 24'd0;
      pad_left_r   <= 8'd0;
      max_size_r   <= MAX_FRAME_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_size_r <= cfg_max_frame_size;
      end
      if (accept) begin
        phase_r      <= phase_nxt;
        hdr_idx_r    <= hdr_idx_nxt;
        len_r        <= len_nxt;
        type_r       <= type_nxt;
        flags_r      <= flags_nxt;
        stream_r     <= stream_nxt;
        bytes_left_r <= bytes_left_nxt;
        pad_left_r   <= pad_left_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      kind_r    <= kind_nxt;
      dbyte_r   <= dbyte_nxt;
      otype_r   <= type_nxt;
      oflags_r  <= flags_nxt;
      olen_r    <= len_nxt;
      ostream_r <= stream_nxt;
      err_r     <= err_nxt;
      fend_r    <= fend_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_data_byte    = dbyte_r;
  assign out_frame_type   = otype_r;
  assign out_frame_flags  = oflags_r;
  assign out_frame_length = olen_r;
  assign out_stream_id    = ostream_r;
  assign out_error_code   = err_r;
  assign out_frame_end    = fend_r;

`ifndef SYNTH
  // once dead, the parser never leaves that phase
  a_dead_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DEAD |=> phase_r == PH_DEAD)
    else $error("parser left the dead phase");

  // an error result sends the parser dead
  a_error_kills: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && kind_nxt == KIND_ERROR |=> phase_r == PH_DEAD)
    else $error("error reported but parser still running");

  // header index only moves during header collection
  a_idx_header: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_idx_r != 4'd0 |-> phase_r == PH_HEADER)
    else $error("header index set outside header phase");

  // padding phase always has bytes to consume
  a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAD |-> pad_left_r != 8'd0)
    else $error("padding phase with no padding left");

  // an error result closes its frame
  a_error_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_ERROR |-> fend_r)
    else $error("error result without frame end");
`endif

endmodule : http2_frame_deframer

`default_nettype wire
